@@ src/bced_pkg.sv @@
`timescale 1ns / 1ps

package bced_pkg;

  localparam int unsigned TICK_BITS_DEF   = 32;
  localparam int unsigned TIMEOUT_BITS    = 32;
  localparam int unsigned SAMPLE_BITS     = 32;
  localparam int unsigned ID_BITS         = 16;
  localparam int unsigned TAG_BITS        = 32;
  localparam int unsigned KIND_BITS       = 3;
  localparam int unsigned LEVEL_BITS      = 2;
  localparam int unsigned CODE_BITS       = 2;
  localparam int unsigned MAX_EVENTS      = 3;
  localparam int unsigned CFG_ADDR_BITS   = 2;
  localparam int unsigned CFG_DATA_BITS   = 32;
  localparam int unsigned IN_DATA_BITS    = 88;
  localparam int unsigned OUT_DATA_BITS   = 104;

  localparam logic [TIMEOUT_BITS-1:0] CLICK_TIMEOUT_RST  = 32'd500;
  localparam logic [TIMEOUT_BITS-1:0] DOUBLE_TIMEOUT_RST = 32'd1000;

  localparam logic [LEVEL_BITS-1:0] LEVEL_ZERO = 2'b00;
  localparam logic [LEVEL_BITS-1:0] LEVEL_POS  = 2'b01;
  localparam logic [LEVEL_BITS-1:0] LEVEL_NEG  = 2'b11;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_MOMENTARY = 3'd0,
    KIND_TOGGLE    = 3'd1,
    KIND_SELECTOR  = 3'd2,
    KIND_ON_OFF    = 3'd3,
    KIND_ONE_SHOT  = 3'd4
  } kind_e;

  typedef enum logic [CODE_BITS-1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_CLICK   = 2'd2,
    EV_DOUBLE  = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    LAST_NONE    = 2'd0,
    LAST_PRESS   = 2'd1,
    LAST_RELEASE = 2'd2
  } last_e;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_BUTTON_KIND    = 2'd0,
    REG_CLICK_TIMEOUT  = 2'd1,
    REG_DOUBLE_TIMEOUT = 2'd2,
    REG_CONTROL_ID     = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]                          cnt;
    logic [MAX_EVENTS-1:0][CODE_BITS-1:0] code;
  } event_set_t;

endpackage

@@ src/button_click_event_detector.sv @@
// a request is held in the input register, then its events go to the output event register
// throughput: one request per cycle when it yields no event and the output event register is empty;
// otherwise events (up to three) leave one by one from the single output event register
// reset: asynchronous active low, clears button state and loads default config
`timescale 1ns / 1ps

module button_click_event_detector #(
  parameter int unsigned TickBits = bced_pkg::TICK_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bced_pkg::CFG_ADDR_BITS-1:0]    cfg_addr_i,
  input  logic [bced_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // button_level, sample_tick, app_ctrl_id, app_ctrl_tag
  input  logic [bced_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // event_code, out_control_id, out_app_ctrl_id, out_app_ctrl_tag, event_tick
  output logic [bced_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
  output logic                                  m_axis_tlast
);

  localparam int unsigned LB = bced_pkg::LEVEL_BITS;
  localparam int unsigned SB = bced_pkg::SAMPLE_BITS;
  localparam int unsigned IB = bced_pkg::ID_BITS;
  localparam int unsigned GB = bced_pkg::TAG_BITS;
  localparam int unsigned CB = bced_pkg::CODE_BITS;
  localparam int unsigned PayBits = CB + IB + IB + GB + SB;

  logic [bced_pkg::KIND_BITS-1:0]    button_kind_q;
  logic [bced_pkg::TIMEOUT_BITS-1:0] click_timeout_q;
  logic [bced_pkg::TIMEOUT_BITS-1:0] double_timeout_q;
  logic [IB-1:0]                     control_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_kind_q    <= bced_pkg::KIND_MOMENTARY;
      click_timeout_q  <= bced_pkg::CLICK_TIMEOUT_RST;
      double_timeout_q <= bced_pkg::DOUBLE_TIMEOUT_RST;
      control_id_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bced_pkg::REG_BUTTON_KIND:    button_kind_q    <= cfg_wdata_i[bced_pkg::KIND_BITS-1:0];
        bced_pkg::REG_CLICK_TIMEOUT:  click_timeout_q  <= cfg_wdata_i;
        bced_pkg::REG_DOUBLE_TIMEOUT: double_timeout_q <= cfg_wdata_i;
        bced_pkg::REG_CONTROL_ID:     control_id_q     <= cfg_wdata_i[IB-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic          in_valid_q;
  logic [LB-1:0] in_level_q;
  logic [SB-1:0] in_tick_q;
  logic [IB-1:0] in_id_q;
  logic [GB-1:0] in_tag_q;

  // output event register
  logic [1:0]                         out_cnt_q;
  logic [bced_pkg::MAX_EVENTS-1:0][CB-1:0] out_code_q;
  logic [IB-1:0]                      out_ctl_q;
  logic [IB-1:0]                      out_id_q;
  logic [GB-1:0]                      out_tag_q;
  logic [SB-1:0]                      out_tick_q;

  logic                 accept, fire, buf_free, take, load;
  bced_pkg::event_set_t evs;

  assign take          = m_axis_tvalid && m_axis_tready;
  assign buf_free      = (out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && m_axis_tready);
  assign fire          = in_valid_q && buf_free;
  assign s_axis_tready = !in_valid_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load          = fire && (evs.cnt != 2'd0);

  bced_core #(
    .TickBits (TickBits)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .level_i          (in_level_q),
    .tick_i           (TickBits'(in_tick_q)),
    .button_kind_i    (button_kind_q),
    .click_timeout_i  (click_timeout_q),
    .double_timeout_i (double_timeout_q),
    .events_o         (evs)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_level_q <= s_axis_tdata[LB-1:0];
      in_tick_q  <= s_axis_tdata[LB+SB-1:LB];
      in_id_q    <= s_axis_tdata[LB+SB+IB-1:LB+SB];
      in_tag_q   <= s_axis_tdata[LB+SB+IB+GB-1:LB+SB+IB];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= 2'd0;
    end else if (load) begin
      out_cnt_q <= evs.cnt;
    end else if (take) begin
      out_cnt_q <= out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_code_q <= evs.code;
      out_ctl_q  <= control_id_q;
      out_id_q   <= in_id_q;
      out_tag_q  <= in_tag_q;
      out_tick_q <= in_tick_q;
    end else if (take) begin
      out_code_q[0] <= out_code_q[1];
      out_code_q[1] <= out_code_q[2];
    end
  end

  assign m_axis_tvalid = (out_cnt_q != 2'd0);
  assign m_axis_tlast  = (out_cnt_q == 2'd1);
  assign m_axis_tdata  = {(bced_pkg::OUT_DATA_BITS - PayBits)'(0),
                          out_tick_q, out_tag_q, out_id_q, out_ctl_q, out_code_q[0]};

endmodule

@@ src/bced_core.sv @@
`timescale 1ns / 1ps

module bced_core #(
  parameter int unsigned TickBits = bced_pkg::TICK_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    fire_i,
  input  logic [bced_pkg::LEVEL_BITS-1:0]         level_i,
  input  logic [TickBits-1:0]                     tick_i,
  input  logic [bced_pkg::KIND_BITS-1:0]          button_kind_i,
  input  logic [bced_pkg::TIMEOUT_BITS-1:0]       click_timeout_i,
  input  logic [bced_pkg::TIMEOUT_BITS-1:0]       double_timeout_i,
  output bced_pkg::event_set_t                    events_o
);

  localparam int unsigned CmpBits =
    (TickBits > bced_pkg::TIMEOUT_BITS) ? TickBits : bced_pkg::TIMEOUT_BITS;

  logic [bced_pkg::LEVEL_BITS-1:0] prev_level_q, prev_level_d;
  bced_pkg::last_e                 last_event_q, last_event_d;
  logic [TickBits-1:0]             press_tick_q, press_tick_d;
  logic [TickBits-1:0]             first_tick_q, first_tick_d;
  logic [1:0]                      click_count_q, click_count_d;

  logic [TickBits-1:0] el_press, el_first;
  logic                click_ok, double_ok;

  assign el_press  = tick_i - press_tick_q;
  assign el_first  = tick_i - first_tick_q;
  assign click_ok  = CmpBits'(el_press) <= CmpBits'(click_timeout_i);
  assign double_ok = CmpBits'(el_first) <= CmpBits'(double_timeout_i);

  always_comb begin
    logic                           has_ev;
    bced_pkg::event_e               ev;
    logic [1:0]                     n;
    logic [1:0]                     cc;
    bced_pkg::event_set_t           evs;
    has_ev        = 1'b0;
    ev            = bced_pkg::EV_PRESS;
    n             = 2'd0;
    cc            = click_count_q;
    evs           = '0;
    prev_level_d  = prev_level_q;
    last_event_d  = last_event_q;
    press_tick_d  = press_tick_q;
    first_tick_d  = first_tick_q;
    click_count_d = click_count_q;

    if (level_i != prev_level_q) begin
      if (level_i == bced_pkg::LEVEL_POS) begin
        case (button_kind_i)
          bced_pkg::KIND_MOMENTARY,
          bced_pkg::KIND_TOGGLE,
          bced_pkg::KIND_SELECTOR,
          bced_pkg::KIND_ONE_SHOT: has_ev = 1'b1;
          bced_pkg::KIND_ON_OFF:   has_ev = (prev_level_q == bced_pkg::LEVEL_ZERO);
          default:                 has_ev = 1'b0;
        endcase
        ev = bced_pkg::EV_PRESS;
      end else if (level_i == bced_pkg::LEVEL_NEG) begin
        has_ev = (button_kind_i == bced_pkg::KIND_ON_OFF) &&
                 (prev_level_q == bced_pkg::LEVEL_ZERO);
        ev     = bced_pkg::EV_RELEASE;
      end else begin
        case (button_kind_i)
          bced_pkg::KIND_MOMENTARY,
          bced_pkg::KIND_TOGGLE,
          bced_pkg::KIND_SELECTOR: has_ev = 1'b1;
          default:                 has_ev = 1'b0;
        endcase
        ev = bced_pkg::EV_RELEASE;
      end

      if (has_ev) begin
        evs.code[n]  = ev;
        n            = n + 2'd1;
        last_event_d = (ev == bced_pkg::EV_PRESS) ? bced_pkg::LAST_PRESS
                                                  : bced_pkg::LAST_RELEASE;
      end

      case (last_event_d)
        bced_pkg::LAST_PRESS: begin
          press_tick_d = tick_i;
          if (!double_ok) begin
            cc = 2'd0;
          end
          if (cc == 2'd0) begin
            first_tick_d = tick_i;
          end
          click_count_d = (cc == 2'd3) ? cc : cc + 2'd1;
        end
        bced_pkg::LAST_RELEASE: begin
          if (click_ok) begin
            evs.code[n] = bced_pkg::EV_CLICK;
            n           = n + 2'd1;
          end
          if (click_count_q == 2'd2) begin
            if (double_ok) begin
              evs.code[n] = bced_pkg::EV_DOUBLE;
              n           = n + 2'd1;
            end
            click_count_d = 2'd0;
          end
        end
        default: ;
      endcase

      prev_level_d = level_i;
    end

    evs.cnt  = n;
    events_o = evs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q  <= bced_pkg::LEVEL_ZERO;
      last_event_q  <= bced_pkg::LAST_NONE;
      press_tick_q  <= '0;
      first_tick_q  <= '0;
      click_count_q <= 2'd0;
    end else if (fire_i) begin
      prev_level_q  <= prev_level_d;
      last_event_q  <= last_event_d;
      press_tick_q  <= press_tick_d;
      first_tick_q  <= first_tick_d;
      click_count_q <= click_count_d;
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam logic [bced_pkg::LEVEL_BITS-1:0] LEVEL_NEG2 = 2'b10;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 55;

  typedef struct packed {
    bced_pkg::event_e code;
    logic [15:0]      ctrl_id;
    logic [15:0]      app_id;
    logic [31:0]      app_tag;
    logic [31:0]      tick;
    logic             run_end;
  } btn_event_t;

  typedef struct packed {
    logic           is_cfg;
    bced_pkg::reg_e addr;
    logic [31:0]    value;
    logic [1:0]     level;
    logic [15:0]    app_id;
    logic [31:0]    tag;
    logic           typed;
    logic [1:0]     n_typed;
    logic [5:0]     codes;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bced_pkg::CFG_ADDR_BITS-1:0] cfg_addr_i = '0;
  logic [bced_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [bced_pkg::IN_DATA_BITS-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [bced_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
  logic m_axis_tlast;

  button_click_event_detector DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  int src_idle_pct = 16;
  int sink_idle_pct = 65;
  int mismatches = 0;

  // shadow configuration
  logic [2:0]  cur_kind = bced_pkg::KIND_MOMENTARY;
  logic [31:0] cur_click_to = bced_pkg::CLICK_TIMEOUT_RST;
  logic [31:0] cur_double_to = bced_pkg::DOUBLE_TIMEOUT_RST;
  logic [15:0] cur_ctrl_id = '0;

  // shadow button state
  logic [1:0]      held_level = bced_pkg::LEVEL_ZERO;
  bced_pkg::last_e last_edge = bced_pkg::LAST_NONE;
  logic [31:0]     press_at = '0;
  logic [31:0]     first_click_at = '0;
  logic [1:0]      clicks = '0;

  btn_event_t new_events[$];
  btn_event_t events_due[$];
  stim_row_t  directed[$];

  function automatic void add_event(bced_pkg::event_e code, logic [31:0] tick,
                                    logic [15:0] app_id, logic [31:0] tag);
    btn_event_t e;
    e.code = code;
    e.ctrl_id = cur_ctrl_id;
    e.app_id = app_id;
    e.app_tag = tag;
    e.tick = tick;
    e.run_end = 1'b0;
    new_events.push_back(e);
  endfunction

  function automatic void predict_events(logic [1:0] level, logic [31:0] tick,
                                         logic [15:0] app_id, logic [31:0] tag);
    bit               has_ev;
    bced_pkg::event_e ev;
    new_events.delete();
    if (level == held_level) return;
    has_ev = 1'b0;
    ev = bced_pkg::EV_PRESS;
    if (level == bced_pkg::LEVEL_POS) begin
      if (cur_kind <= bced_pkg::KIND_SELECTOR || cur_kind == bced_pkg::KIND_ONE_SHOT ||
          (cur_kind == bced_pkg::KIND_ON_OFF && held_level == bced_pkg::LEVEL_ZERO)) begin
        has_ev = 1'b1;
      end
    end else if (level == bced_pkg::LEVEL_NEG) begin
      if (cur_kind == bced_pkg::KIND_ON_OFF && held_level == bced_pkg::LEVEL_ZERO) begin
        has_ev = 1'b1;
        ev = bced_pkg::EV_RELEASE;
      end
    end else if (cur_kind <= bced_pkg::KIND_SELECTOR) begin
      has_ev = 1'b1;
      ev = bced_pkg::EV_RELEASE;
    end
    if (has_ev) begin
      add_event(ev, tick, app_id, tag);
      last_edge = (ev == bced_pkg::EV_PRESS) ? bced_pkg::LAST_PRESS : bced_pkg::LAST_RELEASE;
    end
    if (last_edge == bced_pkg::LAST_PRESS) begin
      press_at = tick;
      if (32'(tick - first_click_at) > cur_double_to) clicks = '0;
      if (clicks == 2'd0) first_click_at = tick;
      if (clicks < 2'd3) clicks = clicks + 2'd1;
    end else if (last_edge == bced_pkg::LAST_RELEASE) begin
      if (32'(tick - press_at) <= cur_click_to) begin
        add_event(bced_pkg::EV_CLICK, tick, app_id, tag);
      end
      if (clicks == 2'd2) begin
        if (32'(tick - first_click_at) <= cur_double_to)
          add_event(bced_pkg::EV_DOUBLE, tick, app_id, tag);
        clicks = '0;
      end
    end
    held_level = level;
    if (new_events.size() > 0) new_events[new_events.size()-1].run_end = 1'b1;
  endfunction

  function automatic stim_row_t cfg_row(bced_pkg::reg_e addr, logic [31:0] value);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.addr = addr;
    r.value = value;
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [1:0] level, logic [31:0] tick,
                                         logic [15:0] app_id, logic [31:0] tag);
    stim_row_t r;
    r = '0;
    r.level = level;
    r.value = tick;
    r.app_id = app_id;
    r.tag = tag;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [1:0] level, logic [31:0] tick,
                                          logic [15:0] app_id, logic [31:0] tag,
                                          logic [1:0] n, bced_pkg::event_e c0,
                                          bced_pkg::event_e c1, bced_pkg::event_e c2);
    stim_row_t r;
    r = item_row(level, tick, app_id, tag);
    r.typed = 1'b1;
    r.n_typed = n;
    r.codes = {c2, c1, c0};
    return r;
  endfunction

  task automatic write_reg(bced_pkg::reg_e addr, logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= value;
    case (addr)
      bced_pkg::REG_BUTTON_KIND:    cur_kind = value[2:0];
      bced_pkg::REG_CLICK_TIMEOUT:  cur_click_to = value;
      bced_pkg::REG_DOUBLE_TIMEOUT: cur_double_to = value;
      bced_pkg::REG_CONTROL_ID:     cur_ctrl_id = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_request(stim_row_t r);
    btn_event_t e;
    int k;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, r.tag, r.app_id, r.value, r.level};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_events(r.level, r.value, r.app_id, r.tag);
    if (r.typed) begin
      for (k = 0; k < r.n_typed; k++) begin
        e.code = bced_pkg::event_e'(r.codes[2*k +: 2]);
        e.ctrl_id = cur_ctrl_id;
        e.app_id = r.app_id;
        e.app_tag = r.tag;
        e.tick = r.value;
        e.run_end = (k == r.n_typed - 1);
        events_due.push_back(e);
      end
    end else begin
      foreach (new_events[k]) events_due.push_back(new_events[k]);
    end
    @(negedge clk_i);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    btn_event_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (events_due.size() == 0) begin
        $error("unexpected event: tdata %0h tlast %0b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        e = events_due.pop_front();
        check_field("event_code", 32'(e.code), 32'(m_axis_tdata[1:0]));
        check_field("out_control_id", 32'(e.ctrl_id), 32'(m_axis_tdata[17:2]));
        check_field("out_app_ctrl_id", 32'(e.app_id), 32'(m_axis_tdata[33:18]));
        check_field("out_app_ctrl_tag", e.app_tag, m_axis_tdata[65:34]);
        check_field("event_tick", e.tick, m_axis_tdata[97:66]);
        check_field("last_of_run", 32'(e.run_end), 32'(m_axis_tlast));
      end
    end
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [31:0] tick_now;
    logic [1:0]  lvl;
    logic [1:0]  last_lvl;
    bit          swing_neg;
    int          ph;
    int          i;
    int          pick;

    // after reset: momentary, click 500, double 1000, id 0
    directed.push_back(known_row(bced_pkg::LEVEL_POS, 32'd100, 16'h0000, 32'h0000_0000,
                                 2'd1, bced_pkg::EV_PRESS, bced_pkg::EV_PRESS,
                                 bced_pkg::EV_PRESS));
    directed.push_back(known_row(bced_pkg::LEVEL_POS, 32'd150, 16'hFFFF, 32'hFFFF_FFFF,
                                 2'd0, bced_pkg::EV_PRESS, bced_pkg::EV_PRESS,
                                 bced_pkg::EV_PRESS));
    directed.push_back(known_row(bced_pkg::LEVEL_ZERO, 32'd300, 16'hFFFF, 32'h0000_0000,
                                 2'd2, bced_pkg::EV_RELEASE, bced_pkg::EV_CLICK,
                                 bced_pkg::EV_PRESS));
    directed.push_back(known_row(bced_pkg::LEVEL_POS, 32'd400, 16'h0000, 32'hFFFF_FFFF,
                                 2'd1, bced_pkg::EV_PRESS, bced_pkg::EV_PRESS,
                                 bced_pkg::EV_PRESS));
    directed.push_back(known_row(bced_pkg::LEVEL_ZERO, 32'd600, 16'hA5A5, 32'h5A5A_A5A5,
                                 2'd3, bced_pkg::EV_RELEASE, bced_pkg::EV_CLICK,
                                 bced_pkg::EV_DOUBLE));
    directed.push_back(known_row(bced_pkg::LEVEL_POS, 32'd1000, 16'h5A5A, 32'hA5A5_5A5A,
                                 2'd1, bced_pkg::EV_PRESS, bced_pkg::EV_PRESS,
                                 bced_pkg::EV_PRESS));
    // one tick past the click timeout
    directed.push_back(known_row(bced_pkg::LEVEL_ZERO, 32'd1501, 16'h0001, 32'h0000_0001,
                                 2'd1, bced_pkg::EV_RELEASE, bced_pkg::EV_PRESS,
                                 bced_pkg::EV_PRESS));
    directed.push_back(known_row(bced_pkg::LEVEL_POS, 32'd2000, 16'h8000, 32'h8000_0000,
                                 2'd1, bced_pkg::EV_PRESS, bced_pkg::EV_PRESS,
                                 bced_pkg::EV_PRESS));
    // click on the boundary, double click window missed
    directed.push_back(known_row(bced_pkg::LEVEL_ZERO, 32'd2500, 16'h7FFF, 32'h7FFF_FFFF,
                                 2'd2, bced_pkg::EV_RELEASE, bced_pkg::EV_CLICK,
                                 bced_pkg::EV_PRESS));
    directed.push_back(known_row(LEVEL_NEG2, 32'd2600, 16'h1234, 32'h1234_5678,
                                 2'd1, bced_pkg::EV_RELEASE, bced_pkg::EV_PRESS,
                                 bced_pkg::EV_PRESS));
    directed.push_back(known_row(bced_pkg::LEVEL_NEG, 32'd2700, 16'h4321, 32'h8765_4321,
                                 2'd0, bced_pkg::EV_PRESS, bced_pkg::EV_PRESS,
                                 bced_pkg::EV_PRESS));
    directed.push_back(known_row(bced_pkg::LEVEL_ZERO, 32'd2800, 16'h0F0F, 32'h0F0F_0F0F,
                                 2'd1, bced_pkg::EV_RELEASE, bced_pkg::EV_PRESS,
                                 bced_pkg::EV_PRESS));
    // tick wraps between press and release
    directed.push_back(known_row(bced_pkg::LEVEL_POS, 32'hFFFF_FF00, 16'hF0F0, 32'hF0F0_F0F0,
                                 2'd1, bced_pkg::EV_PRESS, bced_pkg::EV_PRESS,
                                 bced_pkg::EV_PRESS));
    directed.push_back(known_row(bced_pkg::LEVEL_ZERO, 32'h0000_00F0, 16'hFFFF, 32'hFFFF_FFFF,
                                 2'd2, bced_pkg::EV_RELEASE, bced_pkg::EV_CLICK,
                                 bced_pkg::EV_PRESS));
    directed.push_back(cfg_row(bced_pkg::REG_BUTTON_KIND, 32'(bced_pkg::KIND_ON_OFF)));
    directed.push_back(cfg_row(bced_pkg::REG_CONTROL_ID, 32'h0000_FFFF));
    directed.push_back(cfg_row(bced_pkg::REG_CLICK_TIMEOUT, 32'h0000_0000));
    directed.push_back(cfg_row(bced_pkg::REG_DOUBLE_TIMEOUT, 32'hFFFF_FFFF));
    directed.push_back(item_row(bced_pkg::LEVEL_POS, 32'h200, 16'h0002, 32'h0000_0002));
    directed.push_back(item_row(bced_pkg::LEVEL_NEG, 32'h200, 16'h0003, 32'h0000_0003));
    directed.push_back(item_row(bced_pkg::LEVEL_ZERO, 32'h300, 16'h0004, 32'h0000_0004));
    directed.push_back(item_row(bced_pkg::LEVEL_NEG, 32'h300, 16'h0005, 32'h0000_0005));
    directed.push_back(cfg_row(bced_pkg::REG_BUTTON_KIND, 32'(bced_pkg::KIND_ONE_SHOT)));
    directed.push_back(item_row(bced_pkg::LEVEL_POS, 32'h400, 16'h0006, 32'h0000_0006));
    directed.push_back(item_row(bced_pkg::LEVEL_ZERO, 32'h450, 16'h0007, 32'h0000_0007));
    // unused kind code
    directed.push_back(cfg_row(bced_pkg::REG_BUTTON_KIND, 32'd7));
    directed.push_back(item_row(bced_pkg::LEVEL_POS, 32'h500, 16'h0008, 32'h0000_0008));
    directed.push_back(item_row(LEVEL_NEG2, 32'h510, 16'h0009, 32'h0000_0009));
    directed.push_back(cfg_row(bced_pkg::REG_BUTTON_KIND, 32'(bced_pkg::KIND_TOGGLE)));
    directed.push_back(cfg_row(bced_pkg::REG_CLICK_TIMEOUT, 32'hFFFF_FFFF));
    directed.push_back(cfg_row(bced_pkg::REG_DOUBLE_TIMEOUT, 32'h0000_0000));
    directed.push_back(item_row(bced_pkg::LEVEL_ZERO, 32'h600, 16'h000A, 32'h0000_000A));
    directed.push_back(item_row(bced_pkg::LEVEL_POS, 32'h700, 16'h000B, 32'h0000_000B));
    directed.push_back(item_row(bced_pkg::LEVEL_ZERO, 32'h700, 16'h000C, 32'h0000_000C));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        settle();
        write_reg(directed[i].addr, directed[i].value);
      end else begin
        send_request(directed[i]);
      end
    end

    tick_now = 32'h700;
    last_lvl = held_level;
    swing_neg = 1'b0;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case (ph / 2)
        0: begin src_idle_pct = 16; sink_idle_pct = 65; end
        1: begin src_idle_pct = 65; sink_idle_pct = 16; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      if ($urandom_range(0, 99) < 8) begin
        write_reg(bced_pkg::REG_BUTTON_KIND, $urandom_range(5, 7));
      end else begin
        write_reg(bced_pkg::REG_BUTTON_KIND, $urandom_range(0, 4));
      end
      pick = $urandom_range(0, 9);
      write_reg(bced_pkg::REG_CLICK_TIMEOUT, (pick == 0) ? 32'h0 :
                (pick == 1) ? 32'hFFFF_FFFF : $urandom_range(20, 600));
      pick = $urandom_range(0, 9);
      write_reg(bced_pkg::REG_DOUBLE_TIMEOUT, (pick == 0) ? 32'h0 :
                (pick == 1) ? 32'hFFFF_FFFF : $urandom_range(100, 1500));
      write_reg(bced_pkg::REG_CONTROL_ID, $urandom_range(0, 65535));
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 99) < 90) tick_now = tick_now + $urandom_range(0, 400);
        else tick_now = $urandom;
        if ($urandom_range(0, 99) < 80) begin
          if (cur_kind == bced_pkg::KIND_ON_OFF) begin
            if (last_lvl != bced_pkg::LEVEL_ZERO) begin
              lvl = bced_pkg::LEVEL_ZERO;
            end else begin
              lvl = swing_neg ? bced_pkg::LEVEL_NEG : bced_pkg::LEVEL_POS;
              swing_neg = ~swing_neg;
            end
          end else begin
            lvl = (last_lvl == bced_pkg::LEVEL_POS) ? bced_pkg::LEVEL_ZERO
                                                    : bced_pkg::LEVEL_POS;
          end
        end else begin
          lvl = 2'($urandom_range(0, 3));
        end
        last_lvl = lvl;
        send_request(item_row(lvl, tick_now, 16'($urandom), $urandom));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (2 * DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
